[rtl/gb3_pkg.sv]
// gb3_pkg: shared types, constants and register indexes for the 3x3 gaussian blur block
// used by gb3_ctrl, gb3_dp and the top level under rtl; depends on nothing
package gb3_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT) + 1;
	localparam int FW_W         = 12;
	localparam int FH_W         = 13;
	localparam int CH_W         = 16;
	localparam int SAMPLE_W     = 8;
	localparam int ALPHA_W      = 16;
	localparam int ACC_W        = 24;
	localparam int SCALE_W      = 32;
	localparam int HALF_W       = SCALE_W / 2;
	localparam int PROD_W       = ACC_W + HALF_W;
	localparam int FULL_W       = ACC_W + SCALE_W;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [12:0] WT_CORNER = 13'd4923;
	localparam logic [12:0] WT_EDGE   = 13'd8116;
	localparam logic [13:0] WT_CENTER = 14'd13380;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YUV_MODE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHROMA_NEUTRAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MAX      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE   = 3'd5;

	typedef struct packed {
		logic [FW_W-1:0]    frame_width;
		logic [FH_W-1:0]    frame_height;
		logic               yuv_mode;
		logic [CH_W-1:0]    chroma_neutral;
		logic [CH_W-1:0]    clamp_max;
		logic [SCALE_W-1:0] output_scale;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
		logic mul;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic drain;
		logic emits;
		logic out_busy;
	} stat_t;

endpackage

[rtl/gb3_ram.sv]
// gb3_ram: generic single-port-write, one-read memory with registered read data
// no dependencies
module gb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/gb3_ctrl.sv]
// gb3_ctrl: sequencer that walks one item through read, window update and, when it makes a result, multiply and output
// depends on gb3_pkg
module gb3_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_flush,
	output logic           s_tready,
	input  gb3_pkg::stat_t st,
	output gb3_pkg::cmd_t  cmd
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_EXEC = 5'b00100,
		S_MUL  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	logic   drain_q;
	logic   retry_q;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.capture = s_tvalid;
			S_READ: cmd.read = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			S_MUL:  cmd.mul = 1'b1;
			S_FIN:  cmd.fin = !st.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= 1'b0;
			retry_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						drain_q <= st.drain;
						retry_q <= 1'b0;
						// flush in the middle of a frame does nothing
						if (st.drain || !s_flush) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					if (st.emits) begin
						state_q <= S_MUL;
					end else if (drain_q && !retry_q) begin
						retry_q <= 1'b1;
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					if (!st.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/gb3_dp.sv]
// gb3_dp: line stores, 3x3 window, position counters, weighted sum, scale and output register
// depends on gb3_pkg and gb3_ram
module gb3_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gb3_pkg::cfg_t                   cfg,
	input  logic                            cfg_clear,
	input  gb3_pkg::cmd_t                   cmd,
	output gb3_pkg::stat_t                  st,
	input  logic [gb3_pkg::SAMPLE_W-1:0]    in_sample,
	input  logic [gb3_pkg::ALPHA_W-1:0]     in_alpha,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gb3_pkg::CH_W-1:0]        out_gray,
	output logic [gb3_pkg::CH_W-1:0]        out_chroma,
	output logic [gb3_pkg::ALPHA_W-1:0]     out_alpha,
	output logic                            out_eor,
	output logic                            out_eof
);
	localparam int CW = gb3_pkg::COL_W;
	localparam int RW = gb3_pkg::ROW_W;
	localparam int SW = gb3_pkg::SAMPLE_W;

	logic [gb3_pkg::FW_W-1:0] eff_w;
	logic [gb3_pkg::FH_W-1:0] eff_h;
	logic [CW-1:0]            col_q, ce;
	logic [CW:0]              col_next;
	logic [RW-1:0]            row_q;
	logic [SW-1:0]            win_q [9];
	logic [SW-1:0]            nw [9];
	logic [SW-1:0]            src [9];
	logic [gb3_pkg::ALPHA_W-1:0] alpha_lag_q;
	logic                     real_q;
	logic [SW-1:0]            v_q;
	logic [gb3_pkg::ALPHA_W-1:0] a_q;
	logic [SW-1:0]            older_rd, newer_rd, nv;
	logic [gb3_pkg::ALPHA_W-1:0] alpha_rd;
	logic                     first, rep, in_frame, store_we;
	logic [1:0]               lc, cc;
	logic [SW-1:0]            l0, l1, l2, c0, c1, c2, r0, r1, r2;
	logic [9:0]               corners, edges;
	logic [gb3_pkg::ACC_W-1:0] acc;
	logic [gb3_pkg::ACC_W-1:0] acc_s1;
	logic [gb3_pkg::ALPHA_W-1:0] alpha_s1, alpha_s2;
	logic                     eor_s1, eof_s1, eor_s2, eof_s2;
	logic [gb3_pkg::PROD_W-1:0] p_lo_s2, p_hi_s2;
	logic [gb3_pkg::FULL_W-1:0] full;
	logic [gb3_pkg::ACC_W-1:0] val;
	logic [gb3_pkg::CH_W-1:0] gray;
	logic                     out_valid_q;

	// sizes clamped to the supported range
	always_comb begin
		if (cfg.frame_width == '0) begin
			eff_w = gb3_pkg::FW_W'(1);
		end else if (cfg.frame_width > gb3_pkg::FW_W'(gb3_pkg::MAX_WIDTH)) begin
			eff_w = gb3_pkg::FW_W'(gb3_pkg::MAX_WIDTH);
		end else begin
			eff_w = cfg.frame_width;
		end
		if (cfg.frame_height == '0) begin
			eff_h = gb3_pkg::FH_W'(1);
		end else if (cfg.frame_height > gb3_pkg::FH_W'(gb3_pkg::MAX_HEIGHT)) begin
			eff_h = gb3_pkg::FH_W'(gb3_pkg::MAX_HEIGHT);
		end else begin
			eff_h = cfg.frame_height;
		end
	end

	assign ce       = (gb3_pkg::FW_W'(col_q) >= eff_w) ? '0 : col_q;
	assign col_next = {1'b0, ce} + 1'b1;
	assign in_frame = (row_q <= RW'(eff_h));
	assign first    = (ce == '0) && (row_q >= RW'(2));
	assign store_we = cmd.exec && real_q && in_frame;

	assign st.drain    = (row_q >= RW'(eff_h));
	assign st.emits    = first || (in_frame && ce != '0 && row_q != '0);
	assign st.out_busy = out_valid_q && !out_ready;

	gb3_ram #(.WIDTH(SW), .DEPTH(gb3_pkg::MAX_WIDTH)) u_older (
		.clk(clk), .we(store_we), .waddr(ce), .wdata(newer_rd),
		.re(cmd.read), .raddr(ce), .rdata(older_rd)
	);
	gb3_ram #(.WIDTH(SW), .DEPTH(gb3_pkg::MAX_WIDTH)) u_newer (
		.clk(clk), .we(store_we), .waddr(ce), .wdata(v_q),
		.re(cmd.read), .raddr(ce), .rdata(newer_rd)
	);
	gb3_ram #(.WIDTH(gb3_pkg::ALPHA_W), .DEPTH(gb3_pkg::MAX_WIDTH)) u_alpha (
		.clk(clk), .we(store_we), .waddr(ce), .wdata(a_q),
		.re(cmd.read), .raddr(ce), .rdata(alpha_rd)
	);

	assign nv = real_q ? v_q : newer_rd;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			nw[i] = win_q[i+3];
		end
		nw[6] = older_rd;
		nw[7] = newer_rd;
		nw[8] = nv;
		for (int i = 0; i < 9; i++) begin
			src[i] = first ? win_q[i] : nw[i];
		end
	end

	// end-of-row output uses the window before the shift, others after it
	assign lc  = first ? ((eff_w == gb3_pkg::FW_W'(1)) ? 2'd2 : 2'd1)
	                   : ((ce == CW'(1)) ? 2'd1 : 2'd0);
	assign cc  = first ? 2'd2 : 2'd1;
	assign rep = first ? (row_q == RW'(2)) : (row_q == RW'(1));

	always_comb begin
		unique case (lc)
			2'd0: begin l0 = src[0]; l1 = src[1]; l2 = src[2]; end
			2'd1: begin l0 = src[3]; l1 = src[4]; l2 = src[5]; end
			default: begin l0 = src[6]; l1 = src[7]; l2 = src[8]; end
		endcase
		unique case (cc)
			2'd1: begin c0 = src[3]; c1 = src[4]; c2 = src[5]; end
			default: begin c0 = src[6]; c1 = src[7]; c2 = src[8]; end
		endcase
		r0 = src[6];
		r1 = src[7];
		r2 = src[8];
		// missing top row replicates the row below
		if (rep) begin
			l0 = l1;
			c0 = c1;
			r0 = r1;
		end
		corners = 10'(l0) + 10'(r0) + 10'(l2) + 10'(r2);
		edges   = 10'(c0) + 10'(l1) + 10'(r1) + 10'(c2);
		acc = gb3_pkg::ACC_W'(gb3_pkg::WT_CORNER) * gb3_pkg::ACC_W'(corners)
		    + gb3_pkg::ACC_W'(gb3_pkg::WT_EDGE) * gb3_pkg::ACC_W'(edges)
		    + gb3_pkg::ACC_W'(gb3_pkg::WT_CENTER) * gb3_pkg::ACC_W'(c1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			alpha_lag_q <= '0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.exec) begin
			if (in_frame) begin
				for (int i = 0; i < 9; i++) begin
					win_q[i] <= nw[i];
				end
				alpha_lag_q <= alpha_rd;
			end
			if (row_q > RW'(eff_h)) begin
				col_q <= '0;
				row_q <= '0;
			end else if (gb3_pkg::FW_W'(col_next) >= eff_w) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			real_q <= !st.drain;
			v_q    <= in_sample;
			a_q    <= in_alpha;
		end
		if (cmd.exec) begin
			acc_s1   <= acc;
			alpha_s1 <= alpha_lag_q;
			eor_s1   <= first;
			eof_s1   <= first && (row_q == RW'(eff_h) + 1'b1);
		end
		if (cmd.mul) begin
			p_lo_s2  <= gb3_pkg::PROD_W'(acc_s1)
			          * gb3_pkg::PROD_W'(cfg.output_scale[gb3_pkg::HALF_W-1:0]);
			p_hi_s2  <= gb3_pkg::PROD_W'(acc_s1)
			          * gb3_pkg::PROD_W'(cfg.output_scale[gb3_pkg::SCALE_W-1:gb3_pkg::HALF_W]);
			alpha_s2 <= alpha_s1;
			eor_s2   <= eor_s1;
			eof_s2   <= eof_s1;
		end
		if (cmd.fin) begin
			out_gray   <= gray;
			out_chroma <= cfg.yuv_mode ? cfg.chroma_neutral : gray;
			out_alpha  <= alpha_s2;
			out_eor    <= eor_s2;
			out_eof    <= eof_s2;
		end
	end

	assign full = {p_hi_s2, {gb3_pkg::HALF_W{1'b0}}} + gb3_pkg::FULL_W'(p_lo_s2);
	assign val  = full[gb3_pkg::FULL_W-1:gb3_pkg::SCALE_W];
	assign gray = (val > gb3_pkg::ACC_W'(cfg.clamp_max)) ? cfg.clamp_max
	                                                      : val[gb3_pkg::CH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[rtl/gaussian_blur_3x3_replicate.sv]
// gaussian_blur_3x3_replicate: top level with configuration registers, sequencer and datapath
// depends on gb3_pkg, gb3_ctrl, gb3_dp (and gb3_ram through gb3_dp)
//
// Usage:
// Input items arrive on s_tvalid/s_tready/s_tdata with the flush flag in s_tuser,
// in raster order. Each pixel is blurred with a fixed 3x3 gaussian using edge
// replication, scaled by output_scale (Q16.16) and clamped to the clamp limit.
// Results leave on m_tvalid/m_tready/m_tdata; m_tlast marks the end of an output
// row, m_tuser carries end of frame and a last-result flag that is always set.
// A result appears one row plus one pixel after its pixel; after the last pixel
// of a frame, further items, flush or not, drain the pending outputs of the last row.
// Each item goes from acceptance to the result register through the line store
// read, window update, split 24x32 multiply and clamp into the output register; a
// drain item that needs two stream positions does the read and window update
// twice. One item is in work at a time, so the block takes a new item only once
// the last one is done; an item without a result stops after the window update,
// and a flush in mid-frame is taken without work. The next item is accepted while
// a result waits in the output register; a stalled receiver holds the sequencer
// only when a new result is due.
// Reset clears the stream position, the window and the registers to their
// defaults; line store contents are left as they are. Any configuration write to
// a known register restarts the frame. No clearing pass runs after reset.
module gaussian_blur_3x3_replicate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,  // sketch_value[7:0], alpha_in[23:8]
	input  logic                              s_tuser,  // flush
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [47:0]                       m_tdata,  // gray, chroma, alpha_out
	output logic                              m_tlast,  // end_of_row
	output logic [1:0]                        m_tuser,  // end_of_frame, last_in_run
	input  logic                              cfg_we,
	input  logic [gb3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gb3_pkg::CFG_DATA_W-1:0]    cfg_data
);
	gb3_pkg::cfg_t  cfg_q;
	gb3_pkg::cmd_t  cmd;
	gb3_pkg::stat_t st;
	logic           cfg_hit;
	logic [gb3_pkg::CH_W-1:0]    gray, chroma;
	logic [gb3_pkg::ALPHA_W-1:0] alpha_out;
	logic           eor, eof;

	assign cfg_hit = cfg_we && (cfg_index == gb3_pkg::REG_FRAME_WIDTH
	                         || cfg_index == gb3_pkg::REG_FRAME_HEIGHT
	                         || cfg_index == gb3_pkg::REG_YUV_MODE
	                         || cfg_index == gb3_pkg::REG_CHROMA_NEUTRAL
	                         || cfg_index == gb3_pkg::REG_CLAMP_MAX
	                         || cfg_index == gb3_pkg::REG_OUTPUT_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= gb3_pkg::FW_W'(2048);
			cfg_q.frame_height   <= gb3_pkg::FH_W'(1080);
			cfg_q.yuv_mode       <= 1'b0;
			cfg_q.chroma_neutral <= gb3_pkg::CH_W'(128);
			cfg_q.clamp_max      <= gb3_pkg::CH_W'(255);
			cfg_q.output_scale   <= gb3_pkg::SCALE_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gb3_pkg::REG_FRAME_WIDTH:    cfg_q.frame_width <= cfg_data[gb3_pkg::FW_W-1:0];
				gb3_pkg::REG_FRAME_HEIGHT:   cfg_q.frame_height <= cfg_data[gb3_pkg::FH_W-1:0];
				gb3_pkg::REG_YUV_MODE:       cfg_q.yuv_mode <= cfg_data[0];
				gb3_pkg::REG_CHROMA_NEUTRAL: cfg_q.chroma_neutral <= cfg_data[gb3_pkg::CH_W-1:0];
				gb3_pkg::REG_CLAMP_MAX:      cfg_q.clamp_max <= cfg_data[gb3_pkg::CH_W-1:0];
				gb3_pkg::REG_OUTPUT_SCALE:   cfg_q.output_scale <= cfg_data;
				default: ;
			endcase
		end
	end

	gb3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_flush(s_tuser), .s_tready(s_tready),
		.st(st), .cmd(cmd)
	);

	gb3_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg(cfg_q), .cfg_clear(cfg_hit),
		.cmd(cmd), .st(st),
		.in_sample(s_tdata[7:0]), .in_alpha(s_tdata[23:8]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_gray(gray), .out_chroma(chroma), .out_alpha(alpha_out),
		.out_eor(eor), .out_eof(eof)
	);

	assign m_tdata = {alpha_out, chroma, gray};
	assign m_tlast = eor;
	assign m_tuser = {1'b1, eof};

	// a new result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// end of frame is always also an end of row
	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("end of frame without end of row");

	// a flush in the middle of a frame leaves the block ready again
	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser && !st.drain |=> s_tready)
		else $error("mid-frame flush started work");
endmodule

[tb/tb_gaussian_blur_3x3_replicate.sv]
// tb_gaussian_blur_3x3_replicate: self-checking bench for the 3x3 gaussian blur stream block
// holds its own blur predictor, a bursty pixel driver and a stalling result monitor
// depends on gb3_pkg and gaussian_blur_3x3_replicate
module tb_gaussian_blur_3x3_replicate;
	timeunit 1ns;
	timeprecision 1ps;

	// indexes with no register behind them
	localparam logic [gb3_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [gb3_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [7:0]  sketch;
		logic [15:0] alpha;
		logic        flush;
	} pixel_item_t;

	typedef struct {
		logic [15:0] gray;
		logic [15:0] chroma;
		logic [15:0] alpha;
		logic        eor;
		logic        eof;
		logic        lir;
	} blur_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid, s_tready, s_tuser;
	logic [23:0] s_tdata;
	logic        m_tvalid, m_tready, m_tlast;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	pixel_item_t pixel_queue[$];
	blur_res_t   blur_due[$];
	int          errors = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          run_left = 0;

	// predictor state
	logic [7:0]  line_older[gb3_pkg::MAX_WIDTH];
	logic [7:0]  line_newer[gb3_pkg::MAX_WIDTH];
	logic [15:0] alpha_line[gb3_pkg::MAX_WIDTH];
	logic [7:0]  win[9];
	logic [15:0] alpha_lag;
	int unsigned col_pos, row_pos;
	logic [gb3_pkg::FW_W-1:0]    p_width = 12'd2048;
	logic [gb3_pkg::FH_W-1:0]    p_height = 13'd1080;
	logic                        p_yuv = 1'b0;
	logic [gb3_pkg::CH_W-1:0]    p_chroma = 16'd128;
	logic [gb3_pkg::CH_W-1:0]    p_white = 16'd255;
	logic [gb3_pkg::SCALE_W-1:0] p_scale = 32'd65536;

	gaussian_blur_3x3_replicate dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int unsigned eff_width();
		if (p_width < 1) return 1;
		if (p_width > gb3_pkg::MAX_WIDTH) return gb3_pkg::MAX_WIDTH;
		return p_width;
	endfunction

	function automatic int unsigned eff_height();
		if (p_height < 1) return 1;
		if (p_height > gb3_pkg::MAX_HEIGHT) return gb3_pkg::MAX_HEIGHT;
		return p_height;
	endfunction

	function automatic logic [63:0] win_tap(int unsigned c, int unsigned r, bit top_rep);
		if (r == 0 && top_rep) r = 1;
		return {56'd0, win[c * 3 + r]};
	endfunction

	function automatic void blur_push(int unsigned lc, int unsigned cc, int unsigned rc,
			bit top_rep, logic [15:0] alpha, bit eor, bit eof);
		logic [63:0] corners, edges, acc, val;
		blur_res_t res;
		corners = win_tap(lc, 0, top_rep) + win_tap(rc, 0, top_rep) + win_tap(lc, 2, 0)
			+ win_tap(rc, 2, 0);
		edges = win_tap(cc, 0, top_rep) + win_tap(lc, 1, 0) + win_tap(rc, 1, 0)
			+ win_tap(cc, 2, 0);
		acc = 64'(gb3_pkg::WT_CORNER) * corners + 64'(gb3_pkg::WT_EDGE) * edges
			+ 64'(gb3_pkg::WT_CENTER) * win_tap(cc, 1, 0);
		val = (acc * {32'd0, p_scale}) >> 32;
		if (val > {48'd0, p_white}) val = {48'd0, p_white};
		res.gray = val[15:0];
		res.chroma = p_yuv ? p_chroma : val[15:0];
		res.alpha = alpha;
		res.eor = eor;
		res.eof = eof;
		res.lir = 1'b1;
		blur_due.push_back(res);
	endfunction

	// one stream position, a real pixel or a drain position past the last row
	function automatic int advance_pos(bit real_px, logic [7:0] v, logic [15:0] a);
		int unsigned w, h, r, c;
		int n;
		logic [7:0] o, m;
		logic [15:0] prev;
		w = eff_width();
		h = eff_height();
		r = row_pos;
		c = col_pos;
		n = 0;
		if (c >= w) c = 0;
		if (c == 0 && r >= 2) begin
			blur_push(w == 1 ? 2 : 1, 2, 2, r == 2, alpha_lag, 1, r == h + 1);
			n = 1;
		end
		if (r <= h) begin
			o = line_older[c];
			m = line_newer[c];
			prev = alpha_lag;
			for (int i = 0; i < 6; i++) win[i] = win[i + 3];
			win[6] = o;
			win[7] = m;
			win[8] = real_px ? v : m;
			alpha_lag = alpha_line[c];
			if (real_px) begin
				line_older[c] = m;
				line_newer[c] = v;
				alpha_line[c] = a;
			end
			if (c >= 1 && r >= 1) begin
				blur_push(c == 1 ? 1 : 0, 1, 2, r == 1, prev, 0, 0);
				n = 1;
			end
		end
		if (r >= h + 1) begin
			row_pos = 0;
			col_pos = 0;
		end else begin
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			col_pos = c;
			row_pos = r;
		end
		return n;
	endfunction

	function automatic void predict_item(logic [7:0] v, logic [15:0] a, logic fl);
		int n;
		n = 0;
		if (row_pos < eff_height()) begin
			if (!fl) void'(advance_pos(1, v, a));
		end else begin
			for (int k = 0; k < 2 && n == 0; k++) n = advance_pos(0, 8'd0, 16'd0);
		end
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// driver: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			bit present;
			present = 0;
			if (s_tvalid && s_tready) begin
				predict_item(s_tdata[7:0], s_tdata[23:8], s_tuser);
				void'(pixel_queue.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				present = 1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pixel_queue.size() > 0) begin
				present = 1;
				if (burst_left == 0) burst_left = $urandom_range(1, 24);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			end
			s_tvalid <= present;
			if (present) begin
				s_tdata <= {pixel_queue[0].alpha, pixel_queue[0].sketch};
				s_tuser <= pixel_queue[0].flush;
			end
		end
	end

	// monitor: receiver stalls on runs of its own, then checks each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			blur_res_t want;
			if (m_tvalid && m_tready) begin
				if (blur_due.size() == 0) begin
					report("unexpected result gray", 32'(m_tdata[15:0]), 32'd0);
				end else begin
					want = blur_due.pop_front();
					if (m_tdata[15:0] !== want.gray)
						report("gray", 32'(m_tdata[15:0]), 32'(want.gray));
					if (m_tdata[31:16] !== want.chroma)
						report("chroma", 32'(m_tdata[31:16]), 32'(want.chroma));
					if (m_tdata[47:32] !== want.alpha)
						report("alpha_out", 32'(m_tdata[47:32]), 32'(want.alpha));
					if (m_tlast !== want.eor)
						report("end_of_row", 32'(m_tlast), 32'(want.eor));
					if (m_tuser[0] !== want.eof)
						report("end_of_frame", 32'(m_tuser[0]), 32'(want.eof));
					if (m_tuser[1] !== want.lir)
						report("last_in_run", 32'(m_tuser[1]), 32'(want.lir));
				end
			end
			if (run_left > 0) begin
				run_left--;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				run_left = $urandom_range(0, 30);
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [gb3_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			gb3_pkg::REG_FRAME_WIDTH:    p_width = val[gb3_pkg::FW_W-1:0];
			gb3_pkg::REG_FRAME_HEIGHT:   p_height = val[gb3_pkg::FH_W-1:0];
			gb3_pkg::REG_YUV_MODE:       p_yuv = val[0];
			gb3_pkg::REG_CHROMA_NEUTRAL: p_chroma = val[15:0];
			gb3_pkg::REG_CLAMP_MAX:      p_white = val[15:0];
			gb3_pkg::REG_OUTPUT_SCALE:   p_scale = val;
			default: ;
		endcase
		if (idx <= gb3_pkg::REG_OUTPUT_SCALE) begin
			row_pos = 0;
			col_pos = 0;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pixel_queue.size() != 0 || s_tvalid || blur_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic setup(input int w, input int h, input logic yuv, input logic [15:0] chroma,
			input logic [15:0] white, input logic [31:0] scale);
		wait_idle();
		write_reg(gb3_pkg::REG_FRAME_WIDTH, 32'(w));
		write_reg(gb3_pkg::REG_FRAME_HEIGHT, 32'(h));
		write_reg(gb3_pkg::REG_YUV_MODE, 32'(yuv));
		write_reg(gb3_pkg::REG_CHROMA_NEUTRAL, 32'(chroma));
		write_reg(gb3_pkg::REG_CLAMP_MAX, 32'(white));
		write_reg(gb3_pkg::REG_OUTPUT_SCALE, scale);
	endtask

	task automatic push_item(input logic [7:0] v, input logic [15:0] a, input logic fl);
		pixel_item_t it;
		it.sketch = v;
		it.alpha = a;
		it.flush = fl;
		pixel_queue.push_back(it);
	endtask

	// one frame with random content, stray flushes and a drain with stray pixels
	task automatic queue_frame(input int w, input int h, inout int count);
		int ew, eh;
		ew = (w < 1) ? 1 : (w > gb3_pkg::MAX_WIDTH ? gb3_pkg::MAX_WIDTH : w);
		eh = (h < 1) ? 1 : (h > gb3_pkg::MAX_HEIGHT ? gb3_pkg::MAX_HEIGHT : h);
		for (int i = 0; i < ew * eh; i++) begin
			if ($urandom_range(0, 19) == 0) push_item(8'($urandom), 16'($urandom), 1'b1);
			push_item(8'($urandom), 16'($urandom), 1'b0);
		end
		// the first width-1 drain items are certainly still draining
		for (int i = 0; i < ew - 1; i++)
			push_item(8'($urandom), 16'($urandom), $urandom_range(0, 5) != 0);
		repeat (3) push_item(8'($urandom), 16'($urandom), 1'b1);
		count += ew * eh + ew + 2;
	endtask

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd65536;
			3: return $urandom_range(0, 32'h0003_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_white();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'd255;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int count;
		count = 0;
		for (int i = 0; i < gb3_pkg::MAX_WIDTH; i++) begin
			line_older[i] = '0;
			line_newer[i] = '0;
			alpha_line[i] = '0;
		end
		for (int i = 0; i < 9; i++) win[i] = '0;
		alpha_lag = '0;
		col_pos = 0;
		row_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small frame with full-scale samples, a stray flush and a pixel in the drain
		setup(3, 3, 1'b0, 16'd128, 16'hFFFF, 32'd65536);
		push_item(8'hFF, 16'hFFFF, 1'b0);
		push_item(8'h00, 16'h0000, 1'b0);
		push_item(8'hFF, 16'hFFFF, 1'b0);
		push_item(8'h00, 16'h1234, 1'b1);
		push_item(8'h00, 16'h0000, 1'b0);
		push_item(8'hFF, 16'hFFFF, 1'b0);
		push_item(8'h00, 16'h0001, 1'b0);
		push_item(8'hFF, 16'h8000, 1'b0);
		push_item(8'h80, 16'h7FFF, 1'b0);
		push_item(8'h01, 16'hFFFE, 1'b0);
		push_item(8'hAA, 16'h5555, 1'b0);
		push_item(8'h55, 16'hAAAA, 1'b1);
		repeat (4) push_item(8'h00, 16'h0000, 1'b1);
		// single pixel frame, zero clamp limit, yuv
		setup(1, 1, 1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
		push_item(8'hFF, 16'hFFFF, 1'b0);
		repeat (3) push_item(8'h00, 16'h0000, 1'b1);
		// one column frame, sizes written out of range clamp to the limits
		setup(0, 0, 1'b1, 16'd0, 16'hFFFF, 32'h0001_8000);
		queue_frame(1, 1, count);
		setup(1, 3, 1'b0, 16'd0, 16'hFFFF, 32'h0001_8000);
		queue_frame(1, 3, count);
		wait_idle();
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0);
		queue_frame(1, 3, count);

		count = 0;
		while (count < 560) begin
			setup($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(2, 9),
				$urandom_range(1, 6), 1'($urandom), 16'($urandom), pick_white(),
				pick_scale());
			repeat ($urandom_range(1, 3)) queue_frame(p_width, p_height, count);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("gaussian_blur_3x3_replicate: match");
		else
			$display("gaussian_blur_3x3_replicate: mismatch");
		$finish;
	end

	initial begin
		#4ms;
		$display("gaussian_blur_3x3_replicate: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/gb3_pkg.sv
rtl/gb3_ram.sv
rtl/gb3_ctrl.sv
rtl/gb3_dp.sv
rtl/gaussian_blur_3x3_replicate.sv
tb/tb_gaussian_blur_3x3_replicate.sv
